/* src/ofc_pkg.sv */
package ofc_pkg;

  // Sizes
  localparam int unsigned NUM_AXES  = 10;
  localparam int unsigned NUM_FACES = 20;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned FACE_W    = 5;
  localparam int unsigned THR_W     = 16;
  localparam int unsigned THR2_W    = 2 * THR_W;
  localparam int unsigned SQ_W      = 2 * SAMPLE_W - 1;   // one square of a sample component
  localparam int unsigned SLEN_W    = 32;                 // sum of three squares
  localparam int unsigned PROD_W    = SLEN_W + THR2_W;    // thr^2 * |s|^2
  localparam int unsigned HALF_W    = PROD_W / 2;
  localparam int unsigned RLEN_W    = 29;                 // |r|^2 of every reference axis
  localparam int unsigned PART_W    = HALF_W + RLEN_W;    // one partial product
  localparam int unsigned RHS_W     = PROD_W + RLEN_W;    // thr^2 * |s|^2 * |r|^2
  localparam int unsigned DOT_W     = 32;                 // |dot| stays below 2^31
  localparam int unsigned MAG_W     = DOT_W - 1;
  localparam int unsigned D2_W      = 2 * MAG_W;
  localparam int unsigned LHS_W     = D2_W + 32;          // dot^2 * 2^32

  // APB register map
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;
  localparam logic [0:0]  REG_COS_THRESHOLD = 1'b0;
  localparam logic [THR_W-1:0] THR_RESET = 16'd63898;

  localparam logic [FACE_W-1:0] FACE_NONE = '0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
  } ofc_axis_t;

  // Beat handed from cell to cell
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
    logic [PROD_W-1:0]          p;      // thr^2 * |s|^2
    logic                       done;   // face already decided
    logic [FACE_W-1:0]          face;
  } ofc_beat_t;

  // Reference axes in match order
  localparam ofc_axis_t AXIS_TABLE [NUM_AXES] = '{
    '{ 16'sd112,   -16'sd5392,  16'sd14652},
    '{ 16'sd9696,   16'sd8276, -16'sd9236 },
    '{-16'sd5960,  -16'sd14796, -16'sd356 },
    '{-16'sd6512,   16'sd14676,  16'sd408 },
    '{ 16'sd9376,   16'sd9048,   16'sd9792},
    '{-16'sd15384,  16'sd212,   -16'sd5200},
    '{ 16'sd9308,  -16'sd9392,   16'sd8884},
    '{-16'sd464,   -16'sd6476,  -16'sd14828},
    '{-16'sd15200,  16'sd1672,   16'sd5480},
    '{ 16'sd8676,  -16'sd10664, -16'sd9188}
  };

  // Squared length of a reference axis
  function automatic logic [RLEN_W-1:0] axis_len2(int unsigned idx);
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [63:0]        acc;
    px  = AXIS_TABLE[idx].x * AXIS_TABLE[idx].x;
    py  = AXIS_TABLE[idx].y * AXIS_TABLE[idx].y;
    pz  = AXIS_TABLE[idx].z * AXIS_TABLE[idx].z;
    acc = 64'(unsigned'(px)) + 64'(unsigned'(py)) + 64'(unsigned'(pz));
    return acc[RLEN_W-1:0];
  endfunction

  // Face on the positive side of an axis
  function automatic logic [FACE_W-1:0] face_pos(int unsigned idx);
    return FACE_W'(idx + 1);
  endfunction

  // Face on the negative side of an axis
  function automatic logic [FACE_W-1:0] face_neg(int unsigned idx);
    return FACE_W'(NUM_FACES - idx);
  endfunction

endpackage

/* src/orientation_face_classifier_core.sv */
// Orientation face classifier. Takes one signed 16-bit accelerometer sample
// per cycle (start high, busy is always low) and returns the face number, 1 to
// 20, of the first of ten fixed reference axes whose |cosine| with the sample
// reaches the threshold, or 0 for no match or a zero sample. Every sample gives
// exactly one result, presented on face_o with face_valid_o high for a single
// cycle when its beat leaves the last axis cell: three front stages form
// thr^2 * |s|^2, then each of the ten axis cells takes three stages (dot and
// partial products, squaring, compare). There is no backpressure: the
// receiver must take every result beat as it comes. The threshold lives at
// APB address 0; write it only while no sample is in flight.
module orientation_face_classifier_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample command
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ofc_pkg::SAMPLE_W-1:0] accel_x_i,
  input  logic signed [ofc_pkg::SAMPLE_W-1:0] accel_y_i,
  input  logic signed [ofc_pkg::SAMPLE_W-1:0] accel_z_i,
  // result
  output logic                                face_valid_o,
  output logic [ofc_pkg::FACE_W-1:0]          face_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ofc_pkg::APB_AW-1:0]          paddr,
  input  logic [ofc_pkg::APB_DW-1:0]          pwdata,
  output logic [ofc_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);
  import ofc_pkg::*;

  logic                 reg_wr;
  logic                 reg_sel;
  logic [THR_W-1:0]     thr_q, thr_d;
  logic [THR2_W-1:0]    thr2_q, thr2_d;
  ofc_beat_t            chain [NUM_AXES+1];

  // APB register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1] == REG_COS_THRESHOLD);
  assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign thr_d   = reg_wr ? pwdata[THR_W-1:0] : thr_q;
  assign prdata  = reg_sel ? APB_DW'(thr_q) : '0;

  // Threshold squared, refreshed every cycle
  assign thr2_d = THR2_W'(thr_q) * THR2_W'(thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      thr2_q <= THR2_W'(THR_RESET) * THR2_W'(THR_RESET);
    end else begin
      thr_q  <= thr_d;
      thr2_q <= thr2_d;
    end
  end

  // Never stalls
  assign busy = 1'b0;

  ofc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (start && !busy),
    .accel_x_i (accel_x_i),
    .accel_y_i (accel_y_i),
    .accel_z_i (accel_z_i),
    .thr2_i    (thr2_q),
    .beat_o    (chain[0])
  );

  // One cell per reference axis, in match order
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_cell
    ofc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .beat_i     (chain[g]),
      .axis_i     (AXIS_TABLE[g]),
      .rlen2_i    (axis_len2(g)),
      .face_pos_i (face_pos(g)),
      .face_neg_i (face_neg(g)),
      .beat_o     (chain[g+1])
    );
  end

  // Result beat
  assign face_valid_o = chain[NUM_AXES].valid;
  assign face_o       = chain[NUM_AXES].face;

endmodule

/* src/ofc_front.sv */
module ofc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                take_i,
  input  logic signed [ofc_pkg::SAMPLE_W-1:0] accel_x_i,
  input  logic signed [ofc_pkg::SAMPLE_W-1:0] accel_y_i,
  input  logic signed [ofc_pkg::SAMPLE_W-1:0] accel_z_i,
  input  logic [ofc_pkg::THR2_W-1:0]          thr2_i,
  output ofc_pkg::ofc_beat_t                  beat_o
);
  import ofc_pkg::*;

  // Stage 1: squares of the components
  logic                       s1_valid_q, s1_valid_d;
  logic signed [SAMPLE_W-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic [SQ_W-1:0]            s1_sx_q, s1_sy_q, s1_sz_q;
  logic [SQ_W-1:0]            s1_sx_d, s1_sy_d, s1_sz_d;
  logic                       s1_zero_q, s1_zero_d;
  logic signed [31:0]         sqx, sqy, sqz;

  // Stage 2: squared sample length
  logic                       s2_valid_q;
  logic signed [SAMPLE_W-1:0] s2_x_q, s2_y_q, s2_z_q;
  logic [SLEN_W-1:0]          s2_slen_q, s2_slen_d;
  logic                       s2_zero_q;

  // Stage 3: scaled by threshold squared
  ofc_beat_t                  s3_q, s3_d;

  assign sqx        = accel_x_i * accel_x_i;
  assign sqy        = accel_y_i * accel_y_i;
  assign sqz        = accel_z_i * accel_z_i;
  assign s1_sx_d    = sqx[SQ_W-1:0];
  assign s1_sy_d    = sqy[SQ_W-1:0];
  assign s1_sz_d    = sqz[SQ_W-1:0];
  assign s1_zero_d  = (accel_x_i == '0) && (accel_y_i == '0) && (accel_z_i == '0);
  assign s1_valid_d = take_i;

  assign s2_slen_d = SLEN_W'(s1_sx_q) + SLEN_W'(s1_sy_q) + SLEN_W'(s1_sz_q);

  always_comb begin
    s3_d       = '0;
    s3_d.valid = s2_valid_q;
    s3_d.x     = s2_x_q;
    s3_d.y     = s2_y_q;
    s3_d.z     = s2_z_q;
    s3_d.p     = PROD_W'(s2_slen_q) * PROD_W'(thr2_i);
    // a zero sample is settled at once as no match
    s3_d.done  = s2_zero_q;
    s3_d.face  = FACE_NONE;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_q       <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
      s3_q       <= s3_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    s1_x_q    <= accel_x_i;
    s1_y_q    <= accel_y_i;
    s1_z_q    <= accel_z_i;
    s1_sx_q   <= s1_sx_d;
    s1_sy_q   <= s1_sy_d;
    s1_sz_q   <= s1_sz_d;
    s1_zero_q <= s1_zero_d;
    s2_x_q    <= s1_x_q;
    s2_y_q    <= s1_y_q;
    s2_z_q    <= s1_z_q;
    s2_slen_q <= s2_slen_d;
    s2_zero_q <= s1_zero_q;
  end

  assign beat_o = s3_q;

endmodule

/* src/ofc_cell.sv */
module ofc_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ofc_pkg::ofc_beat_t                beat_i,
  input  ofc_pkg::ofc_axis_t                axis_i,
  input  logic [ofc_pkg::RLEN_W-1:0]        rlen2_i,
  input  logic [ofc_pkg::FACE_W-1:0]        face_pos_i,
  input  logic [ofc_pkg::FACE_W-1:0]        face_neg_i,
  output ofc_pkg::ofc_beat_t                beat_o
);
  import ofc_pkg::*;

  // Stage A: dot product and partial products of the right-hand side
  ofc_beat_t                 a_beat_q;
  logic signed [DOT_W-1:0]   a_dot_q, a_dot_d;
  logic [PART_W-1:0]         a_ph_q, a_ph_d;
  logic [PART_W-1:0]         a_pl_q, a_pl_d;
  logic signed [31:0]        px, py, pz;
  logic signed [DOT_W+1:0]   dot_full;

  // Stage B: dot squared and full right-hand side
  ofc_beat_t                 b_beat_q;
  logic [D2_W-1:0]           b_d2_q, b_d2_d;
  logic [RHS_W-1:0]          b_rhs_q, b_rhs_d;
  logic                      b_neg_q;
  logic [MAG_W-1:0]          mag;
  logic signed [DOT_W-1:0]   dot_neg;

  // Stage C: compare and settle the face
  ofc_beat_t                 c_beat_q, c_beat_d;
  logic [LHS_W-1:0]          lhs;
  logic                      hit;

  assign px       = beat_i.x * axis_i.x;
  assign py       = beat_i.y * axis_i.y;
  assign pz       = beat_i.z * axis_i.z;
  assign dot_full = (DOT_W+2)'(px) + (DOT_W+2)'(py) + (DOT_W+2)'(pz);
  assign a_dot_d  = $signed(dot_full[DOT_W-1:0]);
  assign a_ph_d   = PART_W'(beat_i.p[PROD_W-1:HALF_W]) * PART_W'(rlen2_i);
  assign a_pl_d   = PART_W'(beat_i.p[HALF_W-1:0]) * PART_W'(rlen2_i);

  assign dot_neg  = -a_dot_q;
  assign mag      = a_dot_q[DOT_W-1] ? dot_neg[MAG_W-1:0] : a_dot_q[MAG_W-1:0];
  assign b_d2_d   = D2_W'(mag) * D2_W'(mag);
  assign b_rhs_d  = {a_ph_q, {HALF_W{1'b0}}} + RHS_W'(a_pl_q);

  assign lhs = {b_d2_q, 32'b0};
  assign hit = lhs >= LHS_W'(b_rhs_q);

  // First matching axis wins; a zero dot counts as the positive side
  always_comb begin
    c_beat_d = b_beat_q;
    if (b_beat_q.valid && !b_beat_q.done && hit) begin
      c_beat_d.done = 1'b1;
      c_beat_d.face = b_neg_q ? face_neg_i : face_pos_i;
    end
  end

  // Beat travels with its arithmetic
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_beat_q <= '0;
      b_beat_q <= '0;
      c_beat_q <= '0;
    end else begin
      a_beat_q <= beat_i;
      b_beat_q <= a_beat_q;
      c_beat_q <= c_beat_d;
    end
  end

  // Arithmetic payload
  always_ff @(posedge clk_i) begin
    a_dot_q <= a_dot_d;
    a_ph_q  <= a_ph_d;
    a_pl_q  <= a_pl_d;
    b_d2_q  <= b_d2_d;
    b_rhs_q <= b_rhs_d;
    b_neg_q <= a_dot_q[DOT_W-1];
  end

  assign beat_o = c_beat_q;

endmodule
